FILE: design/sach_pkg.sv
// ----------------------------------------------------------------------------
// sach_pkg
// shared types and constants for the set-associative tag lookup block
// ----------------------------------------------------------------------------
`default_nettype none
package sach_pkg;
    localparam int MaxSets   = 64;
    localparam int MaxWays   = 8;
    localparam int SetBits   = 6;
    localparam int WayBits   = 3;
    localparam int AddrBits  = 32;
    localparam int QueueDepth = 2;

    typedef struct packed {
        logic                is_write;
        logic [AddrBits-1:0] address;
    } req_t;

    typedef struct packed {
        logic               hit;
        logic [WayBits-1:0] way;
        logic [31:0]        hit_total;
        logic [31:0]        miss_total;
        logic [31:0]        read_total;
        logic [31:0]        write_total;
    } resp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_SEND
    } back_state_t;

    localparam logic [1:0] REG_SETS = 2'd0;
    localparam logic [1:0] REG_WAYS = 2'd1;
endpackage
`default_nettype wire

FILE: design/set_assoc_cache_hit_miss_random_top.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_hit_miss_random_top
// set-associative tag lookup with random replacement and access statistics
// ----------------------------------------------------------------------------
// from request accept to result valid: queue write, row read, valid read and
//   victim pick, update; the back end takes no new request until the last
//   result is taken, stepping through row read, compare, write-back, send
// a two-entry request queue keeps accepting while a result waits, until full
// reset: counters and lfsr cleared at once; valid rows cleared by a pass over
//   all 64 sets after reset, during which the back end takes no request
`default_nettype none
module set_assoc_cache_hit_miss_random_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // address
    input  wire logic        s_tuser,   // operation
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [135:0]     m_tdata    // hit, way, hit_total, miss_total,
                                        // read_total, write_total, zero pad
);
    import sach_pkg::*;

    logic [2:0] sets_log2_reg;
    logic [3:0] ways_reg;
    logic       q_valid, q_ready;
    req_t       q_req, in_req;
    resp_t      resp;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // registers at byte addresses 0 and 4
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sets_log2_reg <= 3'd6;
            ways_reg      <= 4'd1;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_SETS[0] && paddr[1:0] == 2'd0)
            begin
                sets_log2_reg <= pwdata[2:0];
            end
            else if (paddr[2] == REG_WAYS[0] && paddr[1:0] == 2'd0)
            begin
                ways_reg <= pwdata[3:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == 3'd0)
        begin
            prdata = {29'd0, sets_log2_reg};
        end
        else if (paddr == 3'd4)
        begin
            prdata = {28'd0, ways_reg};
        end
    end

    assign in_req.is_write = s_tuser;
    assign in_req.address  = s_tdata;

    sach_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    sach_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .set_count_log2 (sets_log2_reg),
        .ways_in_use    (ways_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_req          (q_req),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_resp       (resp)
    );

    assign m_tdata = {4'd0, resp.write_total, resp.read_total, resp.miss_total,
                      resp.hit_total, resp.way, resp.hit};
endmodule
`default_nettype wire

FILE: design/sach_front.sv
// ----------------------------------------------------------------------------
// sach_front
// accepts requests and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none
module sach_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire sach_pkg::req_t in_req,
    output logic               q_valid,
    input  wire logic          q_ready,
    output sach_pkg::req_t     q_req
);
    import sach_pkg::*;

    req_t       slot_reg [QueueDepth];
    logic [1:0] count_reg, count_next;
    logic       wptr_reg, rptr_reg;
    logic       push, pop;

    assign in_ready = (count_reg != 2'(QueueDepth));
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = slot_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= in_req;
        end
    end
endmodule
`default_nettype wire

FILE: design/sach_back.sv
// ----------------------------------------------------------------------------
// sach_back
// set lookup, fill or random replacement, counters and result register
// ----------------------------------------------------------------------------
`default_nettype none
module sach_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [2:0]      set_count_log2,
    input  wire logic [3:0]      ways_in_use,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire sach_pkg::req_t  q_req,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output sach_pkg::resp_t      out_resp
);
    import sach_pkg::*;

    // one set row: all ways side by side, one read and one write per cycle
    logic [MaxWays*AddrBits-1:0] tag_mem [MaxSets];
    logic [MaxWays-1:0]          valid_mem [MaxSets];

    back_state_t state_reg, state_next;
    req_t        req_reg;
    logic [SetBits-1:0]          set_reg;
    logic [MaxWays*AddrBits-1:0] row_reg;
    logic [MaxWays-1:0]          vrow_reg;
    logic [3:0]                  ways_reg;
    logic [15:0] lfsr_reg;
    logic [31:0] hit_cnt_reg, miss_cnt_reg, rd_cnt_reg, wr_cnt_reg;
    resp_t       resp_reg;
    logic               clr_busy_reg;
    logic [SetBits-1:0] clr_idx_reg;
    logic [3:0]         rem_hi_reg;
    logic [WayBits-1:0] vic_reg;

    logic [SetBits-1:0] set_sel;
    logic [3:0]         ways_act;
    logic [MaxWays-1:0] match_vec, free_vec, in_use, fill_mask;
    logic               hit_c, free_c;
    logic [WayBits-1:0] hit_way, free_way, way_c;
    logic [15:0]        lfsr_adv;

    // eight restoring remainder steps on one byte, divisor at most eight
    function automatic logic [3:0] mod_step8(input logic [3:0] rem_in,
                                             input logic [7:0] val,
                                             input logic [3:0] div);
        logic [4:0] r;
        r = {1'b0, rem_in};
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[3:0], val[i]};
            if (r >= {1'b0, div})
            begin
                r = r - {1'b0, div};
            end
        end
        return r[3:0];
    endfunction

    always_comb
    begin
        set_sel = SetBits'(q_req.address) &
                  SetBits'((7'd1 << ((set_count_log2 > 3'd6) ? 3'd6 : set_count_log2)) - 7'd1);
        ways_act = (ways_in_use == 4'd0) ? 4'd1 :
                   ((ways_in_use > 4'(MaxWays)) ? 4'(MaxWays) : ways_in_use);
    end

    always_comb
    begin
        hit_c = 1'b0;
        free_c = 1'b0;
        hit_way = '0;
        free_way = '0;
        for (int w = MaxWays - 1; w >= 0; w--)
        begin
            in_use[w]    = (4'(w) < ways_reg);
            match_vec[w] = in_use[w] && vrow_reg[w] &&
                           (row_reg[w*AddrBits +: AddrBits] == req_reg.address);
            free_vec[w]  = in_use[w] && !vrow_reg[w];
            if (match_vec[w])
            begin
                hit_c = 1'b1;
                hit_way = WayBits'(w);
            end
            if (free_vec[w])
            begin
                free_c = 1'b1;
                free_way = WayBits'(w);
            end
        end
        lfsr_adv  = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5], lfsr_reg[15:1]};
        way_c     = hit_c ? hit_way : (free_c ? free_way : vic_reg);
        fill_mask = MaxWays'(1) << way_c;
    end

    assign q_ready   = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign out_valid = (state_reg == ST_SEND);
    assign out_resp  = resp_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid && q_ready) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SEND;
            ST_SEND:   if (out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lfsr_reg     <= 16'd1;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            rd_cnt_reg   <= '0;
            wr_cnt_reg   <= '0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // clearing pass over the valid rows, one set per cycle
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SetBits'(1);
                if (clr_idx_reg == SetBits'(MaxSets - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                if (hit_c)
                begin
                    hit_cnt_reg <= hit_cnt_reg + 32'd1;
                end
                else
                begin
                    miss_cnt_reg <= miss_cnt_reg + 32'd1;
                    if (!free_c)
                    begin
                        lfsr_reg <= lfsr_adv;
                    end
                end
                if (req_reg.is_write)
                begin
                    wr_cnt_reg <= wr_cnt_reg + 32'd1;
                end
                else
                begin
                    rd_cnt_reg <= rd_cnt_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready && q_valid)
        begin
            req_reg    <= q_req;
            set_reg    <= set_sel;
            ways_reg   <= ways_act;
            row_reg    <= tag_mem[set_sel];
            // victim remainder, high byte first; lfsr holds until update
            rem_hi_reg <= mod_step8(4'd0, lfsr_adv[15:8], ways_act);
        end
        if (state_reg == ST_LOOKUP)
        begin
            vrow_reg <= valid_mem[set_reg];
            vic_reg  <= WayBits'(mod_step8(rem_hi_reg, lfsr_adv[7:0], ways_reg));
        end
        if (clr_busy_reg)
        begin
            valid_mem[clr_idx_reg] <= '0;
        end
        else if (state_reg == ST_UPDATE && !hit_c)
        begin
            valid_mem[set_reg] <= vrow_reg | fill_mask;
        end
        if (state_reg == ST_UPDATE)
        begin
            if (!hit_c)
            begin
                tag_mem[set_reg][way_c*AddrBits +: AddrBits] <= req_reg.address;
            end
            resp_reg.hit         <= hit_c;
            resp_reg.way         <= way_c;
            resp_reg.hit_total   <= hit_c ? hit_cnt_reg + 32'd1 : hit_cnt_reg;
            resp_reg.miss_total  <= hit_c ? miss_cnt_reg : miss_cnt_reg + 32'd1;
            resp_reg.read_total  <= req_reg.is_write ? rd_cnt_reg : rd_cnt_reg + 32'd1;
            resp_reg.write_total <= req_reg.is_write ? wr_cnt_reg + 32'd1 : wr_cnt_reg;
        end
    end
endmodule
`default_nettype wire

FILE: dv/tb_set_assoc_cache_hit_miss_random_top.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_hit_miss_random_top
// checks the tag lookup block against a predictor of the cache and its counters
// ----------------------------------------------------------------------------
`default_nettype none

// scoreboard: models tag store, replacement lfsr and counters
class cache_scoreboard;
    logic [31:0] tags [sach_pkg::MaxSets*sach_pkg::MaxWays];
    bit          valids [sach_pkg::MaxSets*sach_pkg::MaxWays];
    logic [15:0] lfsr;
    logic [31:0] hits, misses, reads, writes;
    int          sets_log2;
    int          ways_cfg;
    sach_pkg::resp_t expected_q [$];
    int          errors;

    function void clear();
        foreach (valids[i])
        begin
            valids[i] = 0;
            tags[i] = '0;
        end
        lfsr = 16'd1;
        hits = 0;
        misses = 0;
        reads = 0;
        writes = 0;
        sets_log2 = 6;
        ways_cfg = 1;
        errors = 0;
    endfunction

    function int active_sets();
        int s;
        s = 1 << (sets_log2 & 7);
        while (s > sach_pkg::MaxSets && s > 1)
            s = s >> 1;
        return s;
    endfunction

    function int active_ways();
        int w;
        w = ways_cfg & 15;
        if (w == 0)
            w = 1;
        if (w > sach_pkg::MaxWays)
            w = sach_pkg::MaxWays;
        return w;
    endfunction

    function void note_request(bit is_write, logic [31:0] addr);
        sach_pkg::resp_t r;
        int base;
        int ways;
        int way;
        bit hit;
        bit filled;
        ways = active_ways();
        base = (addr & (active_sets() - 1)) * sach_pkg::MaxWays;
        hit = 0;
        way = 0;
        for (int w = 0; w < ways; w++)
        begin
            if (!hit && valids[base+w] && tags[base+w] == addr)
            begin
                hit = 1;
                way = w;
            end
        end
        if (hit)
            hits++;
        else
        begin
            misses++;
            filled = 0;
            for (int w = 0; w < ways; w++)
            begin
                if (!filled && !valids[base+w])
                begin
                    valids[base+w] = 1;
                    tags[base+w] = addr;
                    way = w;
                    filled = 1;
                end
            end
            if (!filled)
            begin
                lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
                way = int'(lfsr) % ways;
                tags[base+way] = addr;
            end
        end
        if (is_write)
            writes++;
        else
            reads++;
        r.hit = hit;
        r.way = way[2:0];
        r.hit_total = hits;
        r.miss_total = misses;
        r.read_total = reads;
        r.write_total = writes;
        expected_q.push_back(r);
    endfunction

    function void check_result(logic [135:0] data);
        sach_pkg::resp_t got;
        sach_pkg::resp_t exp;
        // tdata: hit at bit 0, way 3:1, then the four totals
        got.hit = data[0];
        got.way = data[3:1];
        got.hit_total = data[35:4];
        got.miss_total = data[67:36];
        got.read_total = data[99:68];
        got.write_total = data[131:100];
        if (expected_q.size() == 0)
        begin
            $error("result with no request outstanding");
            errors++;
            return;
        end
        exp = expected_q.pop_front();
        if (got.hit !== exp.hit)
        begin
            $error("hit: expected %0d actual %0d", exp.hit, got.hit);
            errors++;
        end
        if (got.way !== exp.way)
        begin
            $error("way: expected %0d actual %0d", exp.way, got.way);
            errors++;
        end
        if (got.hit_total !== exp.hit_total)
        begin
            $error("hit_total: expected %0d actual %0d", exp.hit_total, got.hit_total);
            errors++;
        end
        if (got.miss_total !== exp.miss_total)
        begin
            $error("miss_total: expected %0d actual %0d", exp.miss_total, got.miss_total);
            errors++;
        end
        if (got.read_total !== exp.read_total)
        begin
            $error("read_total: expected %0d actual %0d", exp.read_total, got.read_total);
            errors++;
        end
        if (got.write_total !== exp.write_total)
        begin
            $error("write_total: expected %0d actual %0d", exp.write_total, got.write_total);
            errors++;
        end
    endfunction
endclass

module tb_set_assoc_cache_hit_miss_random_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sach_pkg::*;

    localparam int StallLimit = 20000;   // idle cycles before giving up

    logic         clk;
    logic         rst_n;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;    // address
    logic         s_tuser;    // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;    // hit, way, hit_total, miss_total, read_total, write_total

    // idle rates in percent for sender and receiver
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int sent_count;
    int result_count;
    cache_scoreboard cache_sb;

    // addresses already used, to bias the random part toward hits
    logic [31:0] recent_addrs [$];

    set_assoc_cache_hit_miss_random_top u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // result side: random stall, check on every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                cache_sb.check_result(m_tdata);
                result_count++;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: cycles with nothing accepted on either stream
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // configuration write: setup then access phase
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (index == REG_SETS)
            cache_sb.sets_log2 = value & 7;
        else
            cache_sb.ways_cfg = value & 15;
    endtask

    // send one request, honoring the sender idle rate; valid stays up after
    // the accept so that back-to-back requests need no gap
    task automatic send_request(input bit is_write, input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        s_tuser <= is_write;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        cache_sb.note_request(is_write, addr);
        sent_count++;
        if (recent_addrs.size() >= 32)
            void'(recent_addrs.pop_front());
        recent_addrs.push_back(addr);
    endtask

    // wait until all results are back, plus the block latency
    task automatic drain();
        s_tvalid <= 1'b0;
        while (cache_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic random_requests(input int count);
        logic [31:0] addr;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50 && recent_addrs.size() > 0)
                addr = recent_addrs[$urandom_range(recent_addrs.size() - 1)];
            else if (pick < 85)
                addr = $urandom_range(255);    // small range: same sets, evictions
            else
                addr = $urandom;
            send_request($urandom_range(1), addr);
        end
    endtask

    initial
    begin
        cache_sb = new();
        cache_sb.clear();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        idle_cycles = 0;
        sent_count = 0;
        result_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset geometry, extremes of address, both operations
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b1, 32'h0000_0000);       // hit
        send_request(1'b0, 32'hFFFF_FFFF);
        send_request(1'b1, 32'hFFFF_FFFF);
        send_request(1'b0, 32'h0000_0040);       // same set as 0, one way: evict
        send_request(1'b0, 32'h0000_0000);
        send_request(1'b1, 32'hAAAA_AAAA);
        send_request(1'b0, 32'h5555_5555);
        drain();

        // full associativity: fill a set then force lfsr victims
        write_reg(REG_WAYS, 32'd8);
        for (int i = 0; i < 12; i++)
            send_request(i[0], 32'h100 + (i << 6));
        drain();

        // too many sets clamps to the max, zero ways acts as one
        write_reg(REG_SETS, 32'd7);
        write_reg(REG_WAYS, 32'd0);
        send_request(1'b0, 32'h0000_0003);
        send_request(1'b1, 32'h0000_0043);
        drain();
        // too many ways clamps, single set
        write_reg(REG_WAYS, 32'd15);
        write_reg(REG_SETS, 32'd0);
        send_request(1'b0, 32'h1234_5678);
        send_request(1'b1, 32'h1234_5678);
        drain();

        // random phases across geometries and idle patterns
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            write_reg(REG_SETS, (phase == 5) ? 32'd6 : $urandom_range(6));
            write_reg(REG_WAYS, (phase == 4) ? 32'd1 : $urandom_range(8, 1));
            random_requests(75);
            // hold off until every result has arrived, then continue
            s_tvalid <= 1'b0;
            while (cache_sb.expected_q.size() != 0)
                @(posedge clk);
            random_requests(75);
            drain();
        end

        $display("covered %0d requests, %0d results, over several set and way settings",
            sent_count, result_count);
        $display("idle patterns: none, sender heavy, receiver heavy, both light");
        if (cache_sb.errors == 0 && cache_sb.expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire

FILE: sim.f
design/sach_pkg.sv
design/sach_front.sv
design/sach_back.sv
design/set_assoc_cache_hit_miss_random_top.sv
dv/tb_set_assoc_cache_hit_miss_random_top.sv
